FILE: design/huffenc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// huffenc_pkg
// Shared types and constants for the table-driven Huffman encoder.
// ----------------------------------------------------------------------------
package huffenc_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

    localparam int BYTE_W   = 8;
    localparam int FIELD_W  = 32;
    localparam int LEN_W    = 6;
    // packing window: up to seven held bits plus the longest code
    localparam int BUF_W    = BYTE_W + FIELD_W;
    localparam int CNT_W    = 6;
    localparam int IN_W     = 48;
    localparam int SYMIN_W  = 8;

    localparam logic [CNT_W-1:0] CNT_BYTE      = 6'd8;
    localparam logic [CNT_W-1:0] CNT_TWO_BYTES = 6'd16;
    localparam logic [LEN_W-1:0] LEN_FULL      = 6'd32;

    // item handed from the lookup stage to the bit packer
    typedef struct packed {
        cmd_t                 cmd;
        logic [FIELD_W-1:0]   code;
        logic [LEN_W-1:0]     len;
    } pack_item_t;

endpackage
`default_nettype wire

FILE: design/huffenc_packer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// huffenc_packer
// MSB-first bit packer: merges code bits behind the held partial byte and
// pops one finished byte per cycle into the output register while it is free.
// ----------------------------------------------------------------------------
module huffenc_packer (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   item_valid,
    output logic                                        item_ready,
    input  wire huffenc_pkg::pack_item_t                item,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [huffenc_pkg::BYTE_W-1:0]              m_tdata,  // packed_byte
    output logic                                        m_tlast   // last_of_run
);

    // window is left aligned: valid bits sit at the top, zeros below
    logic [huffenc_pkg::BUF_W-1:0]   buf_reg, buf_next, buf_a;
    logic [huffenc_pkg::CNT_W-1:0]   cnt_reg, cnt_next, cnt_a;
    logic                            out_valid_reg, out_valid_next;
    logic [huffenc_pkg::BYTE_W-1:0]  out_data_reg, out_data_next;
    logic                            out_last_reg, out_last_next;
    logic                            out_free, pop, take;
    logic [huffenc_pkg::FIELD_W-1:0] code_left;

    always_comb begin
        out_free = !out_valid_reg || m_tready;
        pop      = (cnt_reg >= huffenc_pkg::CNT_BYTE) && out_free;
        buf_a    = pop ? {buf_reg[huffenc_pkg::BUF_W-huffenc_pkg::BYTE_W-1:0],
                          {huffenc_pkg::BYTE_W{1'b0}}} : buf_reg;
        cnt_a    = pop ? cnt_reg - huffenc_pkg::CNT_BYTE : cnt_reg;

        item_ready = cnt_a < huffenc_pkg::CNT_BYTE;
        take       = item_valid && item_ready;

        // drops code bits above the length; zero length gives zero
        code_left = item.code << (huffenc_pkg::LEN_FULL - item.len);

        buf_next = buf_a;
        cnt_next = cnt_a;
        if (take) begin
            case (item.cmd)
                huffenc_pkg::CMD_ENCODE: begin
                    buf_next = {buf_a[huffenc_pkg::BUF_W-1 -: huffenc_pkg::BYTE_W],
                                {huffenc_pkg::FIELD_W{1'b0}}}
                             | ({code_left, {huffenc_pkg::BYTE_W{1'b0}}} >> cnt_a[2:0]);
                    cnt_next = cnt_a + item.len;
                end
                huffenc_pkg::CMD_FLUSH: begin
                    // zero padding is already in place below the held bits
                    if (cnt_a != '0) begin
                        cnt_next = huffenc_pkg::CNT_BYTE;
                    end
                end
                default: begin
                end
            endcase
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (pop) begin
            out_valid_next = 1'b1;
            out_data_next  = buf_reg[huffenc_pkg::BUF_W-1 -: huffenc_pkg::BYTE_W];
            out_last_next  = cnt_reg < huffenc_pkg::CNT_TWO_BYTES;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            buf_reg       <= buf_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

FILE: design/huffman_table_encoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_table_encoder_top
// Table-driven Huffman encoder with an MSB-first byte packer.
// ----------------------------------------------------------------------------
// A load transfer writes one symbol's code and length into a single-port code
// memory (SYMBOL_COUNT entries); per-entry valid flops, cleared at reset, make
// an unloaded symbol read as length zero, so no clearing pass is needed.
// An encode transfer reads the memory into a register; the packer then merges
// the code behind the held partial byte. Items enter one per cycle while the
// packer takes them; it emits one byte per cycle unless the output stalls, so
// an item completing k bytes (at most four for a 32-bit code) holds it until
// they pop. Data passes the read register, the packer window and the output
// register in turn. A flush pads the partial byte with zeros.
// ----------------------------------------------------------------------------
module huffman_table_encoder_top #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // symbol[7:0], code_value[39:8], code_length[45:40], zero[47:46]
    input  wire logic [huffenc_pkg::IN_W-1:0]     s_tdata,
    // command[1:0]
    input  wire logic [1:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // packed_byte[7:0]
    output logic [huffenc_pkg::BYTE_W-1:0]        m_tdata,
    output logic                                  m_tlast
);

    localparam int CODE_W = (MAX_CODE_LEN > huffenc_pkg::FIELD_W) ?
                            huffenc_pkg::FIELD_W : MAX_CODE_LEN;
    localparam int SYM_W  = $clog2(SYMBOL_COUNT);
    localparam logic [huffenc_pkg::LEN_W-1:0] LEN_CAP = huffenc_pkg::LEN_W'(CODE_W);

    typedef struct packed {
        logic [CODE_W-1:0]              code;
        logic [huffenc_pkg::LEN_W-1:0]  len;
    } entry_t;

    entry_t                              code_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0]             valid_reg;

    huffenc_pkg::cmd_t                   in_cmd;
    logic [huffenc_pkg::SYMIN_W-1:0]     in_sym;
    logic [huffenc_pkg::FIELD_W-1:0]     in_code;
    logic [huffenc_pkg::LEN_W-1:0]       in_len, len_sat;
    logic                                in_range, s_accept, do_load;
    logic [SYM_W-1:0]                    sym_idx;

    logic                                s1_valid_reg, s1_valid_next;
    huffenc_pkg::cmd_t                   s1_cmd_reg;
    logic                                hit_reg;
    entry_t                              rd_reg;

    huffenc_pkg::pack_item_t             pk_item;
    logic                                pk_ready, pk_take;

    always_comb begin
        in_cmd   = huffenc_pkg::cmd_t'(s_tuser);
        in_sym   = s_tdata[7:0];
        in_code  = s_tdata[39:8];
        in_len   = s_tdata[45:40];
        in_range = {1'b0, in_sym} < 9'(SYMBOL_COUNT);
        sym_idx  = in_sym[SYM_W-1:0];
        len_sat  = (in_len > LEN_CAP) ? LEN_CAP : in_len;
        s_accept = s_tvalid && s_tready;
        do_load  = s_accept && (in_cmd == huffenc_pkg::CMD_LOAD) && in_range;

        pk_take       = s1_valid_reg && pk_ready;
        s_tready      = !s1_valid_reg || pk_ready;
        s1_valid_next = s_accept ? 1'b1 : (pk_take ? 1'b0 : s1_valid_reg);

        pk_item.cmd  = s1_cmd_reg;
        pk_item.code = hit_reg ? huffenc_pkg::FIELD_W'(rd_reg.code) : '0;
        pk_item.len  = hit_reg ? rd_reg.len : '0;
    end

    // code memory: written by load, read by every accepted item
    always_ff @(posedge aclk) begin
        if (do_load) begin
            code_mem[sym_idx] <= '{code: in_code[CODE_W-1:0], len: len_sat};
        end
        if (s_accept) begin
            rd_reg <= code_mem[sym_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (do_load) begin
                valid_reg[sym_idx] <= 1'b1;
            end
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cmd_reg <= in_cmd;
            hit_reg    <= in_range && valid_reg[sym_idx];
        end
    end

    huffenc_packer u_packer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s1_valid_reg),
        .item_ready (pk_ready),
        .item       (pk_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
`default_nettype wire

FILE: design/huffenc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// huffenc_checker
// Port-level checks for the Huffman encoder, bound to the top level.
// ----------------------------------------------------------------------------
module huffenc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [huffenc_pkg::IN_W-1:0]  s_tdata,
    input wire logic [1:0]                    s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [huffenc_pkg::BYTE_W-1:0] m_tdata,
    input wire logic                          m_tlast
);

    // reset empties the output and opens the input
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output or input side not idle after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output transfer changed");

    // remaining bytes of a run are already packed, so they follow at once
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a run of output bytes");

    // input side never stalls while the output stays empty after idle input
    a_input_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && $past(!m_tvalid) && $past(!s_tvalid) |-> s_tready)
        else $error("input stalled with idle output");

endmodule

bind huffman_table_encoder_top huffenc_checker u_huffenc_checker (.*);
`default_nettype wire
